FILE: src/wptrl_pkg.sv
// shared widths, register indexes and types for the windowed peak run-length encoder
package wptrl_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int RUN_BITS = 32;
   localparam int WLEN_BITS = 16;
   localparam int THR_BITS = 12;
   localparam int RSP_RUN_BITS = 32;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS = 16;
   localparam int CMP_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_THRESHOLD     = 1'b1
   } csr_index_type;

   // window decision handed from the window tracker to the run tracker
   typedef struct packed {
      logic close;
      logic lvl;
   } decision_type;

endpackage

FILE: src/wptrl_window.sv
// window sample counter, running peak and threshold decision
module wptrl_window (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic [wptrl_pkg::SAMPLE_BITS-1:0]  sample,
   input  logic [wptrl_pkg::WLEN_BITS-1:0]    window_length,
   input  logic [wptrl_pkg::THR_BITS-1:0]     threshold,
   output wptrl_pkg::decision_type            decision
);

   logic [wptrl_pkg::WLEN_BITS-1:0]   count_ff, count_in, count_inc, len;
   logic [wptrl_pkg::SAMPLE_BITS-1:0] peak_ff, peak_in, peak_new;

   always_comb begin
      count_inc = (count_ff != '1) ? count_ff + 1'b1 : count_ff;
      len = (window_length == '0) ? wptrl_pkg::WLEN_BITS'(1) : window_length;
      peak_new = (sample > peak_ff) ? sample : peak_ff;
      decision.close = count_inc >= len;
      decision.lvl = wptrl_pkg::CMP_BITS'(peak_new) >= wptrl_pkg::CMP_BITS'(threshold);
      count_in = count_ff;
      peak_in = peak_ff;
      if (step) begin
         if (decision.close) begin
            count_in = '0;
            peak_in = '0;
         end else begin
            count_in = count_inc;
            peak_in = peak_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         peak_ff <= '0;
      end else begin
         count_ff <= count_in;
         peak_ff <= peak_in;
      end
   end

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      step && decision.close |=> count_ff == '0 && peak_ff == '0)
      else $error("window state not cleared after close");

   a_count_below_top: assert property (@(posedge clock) disable iff (reset)
      count_ff != '1)
      else $error("window count reached its top value");

endmodule

FILE: src/wptrl_run.sv
// held level, saturating run counter and change detection
module wptrl_run (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  wptrl_pkg::decision_type              decision,
   output logic                                 emit,
   output logic                                 level,
   output logic [wptrl_pkg::RSP_RUN_BITS-1:0]   run_length
);

   logic [wptrl_pkg::RUN_BITS-1:0] run_ff, run_in, run_inc;
   logic known_ff, known_in;
   logic held_ff, held_in;
   logic change;

   always_comb begin
      run_inc = (run_ff != '1) ? run_ff + 1'b1 : run_ff;
      change = decision.close && (!known_ff || held_ff != decision.lvl);
      emit = step && change && known_ff;
      level = held_ff;
      run_length = wptrl_pkg::RSP_RUN_BITS'(run_inc);
      run_in = run_ff;
      known_in = known_ff;
      held_in = held_ff;
      if (step) begin
         if (change) begin
            run_in = '0;
            known_in = 1'b1;
            held_in = decision.lvl;
         end else begin
            run_in = run_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
         known_ff <= 1'b0;
         held_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         known_ff <= known_in;
         held_ff <= held_in;
      end
   end

   a_emit_flips: assert property (@(posedge clock) disable iff (reset)
      emit |=> held_ff != $past(held_ff) && run_ff == '0 && known_ff)
      else $error("level change did not update run state");

   a_first_silent: assert property (@(posedge clock) disable iff (reset)
      !known_ff |-> !emit)
      else $error("result emitted before any level was known");

endmodule

FILE: src/windowed_peak_threshold_run_length.sv
// top level: input register, window and run trackers, result register
// Takes one 12-bit sample per transfer and can accept a sample in every cycle while
// req_ready is high; each sample passes through the input register, and its result, if any,
// is loaded into the result register, which drives the result transfer. The largest sample
// of each window of window_length samples (zero counts as one) is compared with threshold;
// a peak at or above it is level one. When the decided level differs from the held one, a
// transfer carries the old level and the number of samples in that run, including the
// deciding sample, saturating at the top of the run counter. The first decision after reset
// is adopted silently. While a result waits on rsp_ready the input register takes at most
// one more sample; req_ready then stays low until rsp_ready frees the result register.
// Write csr registers only while the block is idle: index 0 is window_length, 1 is threshold.
module windowed_peak_threshold_run_length (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [wptrl_pkg::SAMPLE_BITS-1:0]     req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_level,
   output logic [wptrl_pkg::RSP_RUN_BITS-1:0]    rsp_run_length,
   input  logic                                  csr_write_enable,
   input  logic [wptrl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [wptrl_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   // configuration registers
   logic [wptrl_pkg::WLEN_BITS-1:0] wlen_ff, wlen_in;
   logic [wptrl_pkg::THR_BITS-1:0]  thr_ff, thr_in;

   // input register
   logic                             in_valid_ff, in_valid_in;
   logic [wptrl_pkg::SAMPLE_BITS-1:0] sample_ff, sample_in;

   // result register
   logic                              out_valid_ff, out_valid_in;
   logic                              level_ff, level_in;
   logic [wptrl_pkg::RSP_RUN_BITS-1:0] run_length_ff, run_length_in;

   logic                               advance;
   logic                               emit;
   logic                               emit_level;
   logic [wptrl_pkg::RSP_RUN_BITS-1:0] emit_run_length;
   wptrl_pkg::decision_type            decision;

   // sample moves into the trackers when the result register can take its outcome
   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      wlen_in = wlen_ff;
      thr_in = thr_ff;
      if (csr_write_enable) begin
         unique case (wptrl_pkg::csr_index_type'(csr_index))
            wptrl_pkg::CSR_WINDOW_LENGTH: wlen_in = csr_write_data;
            wptrl_pkg::CSR_THRESHOLD:     thr_in = csr_write_data[wptrl_pkg::THR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      sample_in = sample_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         sample_in = req_sample;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      level_in = level_ff;
      run_length_in = run_length_ff;
      if (advance) begin
         out_valid_in = emit;
         if (emit) begin
            level_in = emit_level;
            run_length_in = emit_run_length;
         end
      end
   end

   wptrl_window u_window (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .sample        (sample_ff),
      .window_length (wlen_ff),
      .threshold     (thr_ff),
      .decision      (decision)
   );

   wptrl_run u_run (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .decision   (decision),
      .emit       (emit),
      .level      (emit_level),
      .run_length (emit_run_length)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= wptrl_pkg::WLEN_BITS'(1);
         thr_ff <= '0;
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wlen_ff <= wlen_in;
         thr_ff <= thr_in;
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      level_ff <= level_in;
      run_length_ff <= run_length_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_level = level_ff;
   assign rsp_run_length = run_length_ff;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> !req_ready)
      else $error("input accepted while input register is stuck");

endmodule
